>>> rtl/scp_pkg.sv
// Shared types and constants for the sphere collision projection block.
`default_nettype none
package scp_pkg;

    localparam int CoordW   = 32;
    localparam int RadW     = 31;
    localparam int ProdW    = 62;
    localparam int SumW     = 64;
    localparam int RootW    = 32;
    localparam int SqRemW   = 36;
    localparam int NumW     = 63;
    localparam int QuotW    = 32;
    localparam int DivRemW  = 33;
    localparam int OffW     = 34;
    localparam int CfgIdxW  = 3;
    localparam int SqrtSteps = 32;
    localparam int DivSteps  = 32;

    localparam logic [CfgIdxW-1:0] CfgCentreX = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgCentreY = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgCentreZ = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgRadius  = 3'd3;

    localparam logic [RadW-1:0] RadiusReset = 31'd65536;

    typedef struct packed {
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic signed [CoordW-1:0] pos_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [CoordW-1:0] new_x;
        logic signed [CoordW-1:0] new_y;
        logic signed [CoordW-1:0] new_z;
        logic                     moved;
        logic                     degenerate;
    } out_beat_t;

    typedef struct packed {
        in_beat_t              pos;
        logic [2:0]            neg;
        logic [2:0][ProdW-1:0] prod;
        logic                  moved;
        logic                  degen;
    } side_t;

endpackage
`default_nettype wire

>>> rtl/scp_front.sv
// Displacement, squares, products and inside test: three pipeline stages.
`default_nettype none
module scp_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 advance,
    input  wire logic                                 in_valid,
    input  wire scp_pkg::in_beat_t                    in_data,
    input  wire logic signed [scp_pkg::CoordW-1:0]    centre_x,
    input  wire logic signed [scp_pkg::CoordW-1:0]    centre_y,
    input  wire logic signed [scp_pkg::CoordW-1:0]    centre_z,
    input  wire logic [scp_pkg::RadW-1:0]             radius,
    output logic                                      out_valid,
    output logic [scp_pkg::SumW-1:0]                  out_sum,
    output scp_pkg::side_t                            out_side
);

    logic signed [2:0][scp_pkg::CoordW:0] d;
    logic [2:0][scp_pkg::CoordW:0]        a;
    logic [2:0]                           fit;

    logic                                 a_valid_reg;
    scp_pkg::in_beat_t                    a_pos_reg;
    logic [2:0]                           a_neg_reg;
    logic [2:0][scp_pkg::RadW-1:0]        a_mag_reg;
    logic                                 a_degen_reg;
    logic                                 a_fit_reg;

    logic                                 b_valid_reg;
    scp_pkg::in_beat_t                    b_pos_reg;
    logic [2:0]                           b_neg_reg;
    logic [2:0][scp_pkg::ProdW-1:0]       b_sq_reg;
    logic [2:0][scp_pkg::ProdW-1:0]       b_prod_reg;
    logic [scp_pkg::ProdW-1:0]            b_rr_reg;
    logic                                 b_degen_reg;
    logic                                 b_fit_reg;

    logic                                 c_valid_reg;
    logic [scp_pkg::SumW-1:0]             c_sum_reg;
    scp_pkg::side_t                       c_side_reg;

    logic [scp_pkg::SumW-1:0]             sum_next;

    always_comb
    begin
        d[0] = {in_data.pos_x[31], in_data.pos_x} - {centre_x[31], centre_x};
        d[1] = {in_data.pos_y[31], in_data.pos_y} - {centre_y[31], centre_y};
        d[2] = {in_data.pos_z[31], in_data.pos_z} - {centre_z[31], centre_z};
        for (int i = 0; i < 3; i++)
        begin
            a[i]   = d[i][scp_pkg::CoordW] ? 33'(-d[i]) : 33'(d[i]);
            fit[i] = a[i] <= {2'b00, radius};
        end
        sum_next = scp_pkg::SumW'(b_sq_reg[0]) + scp_pkg::SumW'(b_sq_reg[1])
                 + scp_pkg::SumW'(b_sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_pos_reg   <= in_data;
            a_degen_reg <= (a[0] == '0) && (a[1] == '0) && (a[2] == '0);
            a_fit_reg   <= &fit;
            for (int i = 0; i < 3; i++)
            begin
                a_neg_reg[i] <= d[i][scp_pkg::CoordW];
                a_mag_reg[i] <= a[i][scp_pkg::RadW-1:0];
            end

            b_pos_reg   <= a_pos_reg;
            b_neg_reg   <= a_neg_reg;
            b_degen_reg <= a_degen_reg;
            b_fit_reg   <= a_fit_reg;
            b_rr_reg    <= scp_pkg::ProdW'(radius) * scp_pkg::ProdW'(radius);
            for (int i = 0; i < 3; i++)
            begin
                b_sq_reg[i]   <= scp_pkg::ProdW'(a_mag_reg[i]) * scp_pkg::ProdW'(a_mag_reg[i]);
                b_prod_reg[i] <= scp_pkg::ProdW'(a_mag_reg[i]) * scp_pkg::ProdW'(radius);
            end

            c_sum_reg        <= sum_next;
            c_side_reg.pos   <= b_pos_reg;
            c_side_reg.neg   <= b_neg_reg;
            c_side_reg.prod  <= b_prod_reg;
            c_side_reg.degen <= b_degen_reg;
            c_side_reg.moved <= b_fit_reg && !b_degen_reg
                                && (sum_next <= scp_pkg::SumW'(b_rr_reg));
        end
    end

    assign out_valid = c_valid_reg;
    assign out_sum   = c_sum_reg;
    assign out_side  = c_side_reg;

endmodule
`default_nettype wire

>>> rtl/scp_sqrt.sv
// Pipelined square root, one result bit per stage, rounded to nearest.
`default_nettype none
module scp_sqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire logic                        in_valid,
    input  wire logic [scp_pkg::SumW-1:0]    in_sum,
    input  wire scp_pkg::side_t              in_side,
    output logic                             out_valid,
    output logic [scp_pkg::RootW-1:0]        out_len,
    output scp_pkg::side_t                   out_side
);

    logic                        vld_reg  [scp_pkg::SqrtSteps];
    logic [scp_pkg::SumW-1:0]    rad_reg  [scp_pkg::SqrtSteps];
    logic [scp_pkg::SqRemW-1:0]  rem_reg  [scp_pkg::SqrtSteps];
    logic [scp_pkg::RootW-1:0]   root_reg [scp_pkg::SqrtSteps];
    scp_pkg::side_t              side_reg [scp_pkg::SqrtSteps];

    logic                        len_valid_reg;
    logic [scp_pkg::RootW-1:0]   len_reg;
    scp_pkg::side_t              len_side_reg;

    for (genvar k = 0; k < scp_pkg::SqrtSteps; k++)
    begin : g_step
        logic                        vld_in;
        logic [scp_pkg::SumW-1:0]    rad_in;
        logic [scp_pkg::SqRemW-1:0]  rem_in;
        logic [scp_pkg::RootW-1:0]   root_in;
        scp_pkg::side_t              side_in;
        logic [scp_pkg::SqRemW-1:0]  rem_sh;
        logic [scp_pkg::SqRemW-1:0]  trial;
        logic                        take;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign rad_in  = in_sum;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign rem_sh = {rem_in[scp_pkg::SqRemW-3:0], rad_in[scp_pkg::SumW-1 -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign take   = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (advance)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rad_reg[k]  <= {rad_in[scp_pkg::SumW-3:0], 2'b00};
                rem_reg[k]  <= take ? rem_sh - trial : rem_sh;
                root_reg[k] <= {root_in[scp_pkg::RootW-2:0], take};
                side_reg[k] <= side_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_valid_reg <= 1'b0;
        else if (advance)
            len_valid_reg <= vld_reg[scp_pkg::SqrtSteps-1];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            len_reg <= root_reg[scp_pkg::SqrtSteps-1]
                     + scp_pkg::RootW'(rem_reg[scp_pkg::SqrtSteps-1]
                         > scp_pkg::SqRemW'(root_reg[scp_pkg::SqrtSteps-1]));
            len_side_reg <= side_reg[scp_pkg::SqrtSteps-1];
        end
    end

    assign out_valid = len_valid_reg;
    assign out_len   = len_reg;
    assign out_side  = len_side_reg;

endmodule
`default_nettype wire

>>> rtl/scp_div.sv
// Pipelined restoring divider for three axes, one quotient bit per stage.
`default_nettype none
module scp_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             advance,
    input  wire logic                             in_valid,
    input  wire logic [scp_pkg::RootW-1:0]        in_len,
    input  wire scp_pkg::side_t                   in_side,
    output logic                                  out_valid,
    output logic [2:0][scp_pkg::QuotW-1:0]        out_quot,
    output scp_pkg::side_t                        out_side
);

    logic [2:0][scp_pkg::NumW-1:0]     num;

    logic                              init_valid_reg;
    logic [scp_pkg::RootW-1:0]         init_len_reg;
    logic [2:0][scp_pkg::DivRemW-1:0]  init_rem_reg;
    logic [2:0][scp_pkg::QuotW-1:0]    init_low_reg;
    scp_pkg::side_t                    init_side_reg;

    logic                              vld_reg  [scp_pkg::DivSteps];
    logic [scp_pkg::RootW-1:0]         len_reg  [scp_pkg::DivSteps];
    logic [2:0][scp_pkg::DivRemW-1:0]  rem_reg  [scp_pkg::DivSteps];
    logic [2:0][scp_pkg::QuotW-1:0]    low_reg  [scp_pkg::DivSteps];
    logic [2:0][scp_pkg::QuotW-1:0]    quot_reg [scp_pkg::DivSteps];
    scp_pkg::side_t                    side_reg [scp_pkg::DivSteps];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            num[i] = scp_pkg::NumW'(in_side.prod[i]) + scp_pkg::NumW'(in_len >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            init_valid_reg <= 1'b0;
        else if (advance)
            init_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            init_len_reg  <= in_len;
            init_side_reg <= in_side;
            for (int i = 0; i < 3; i++)
            begin
                init_rem_reg[i] <= scp_pkg::DivRemW'(num[i][scp_pkg::NumW-1:scp_pkg::QuotW]);
                init_low_reg[i] <= num[i][scp_pkg::QuotW-1:0];
            end
        end
    end

    for (genvar k = 0; k < scp_pkg::DivSteps; k++)
    begin : g_step
        logic                              vld_in;
        logic [scp_pkg::RootW-1:0]         len_in;
        logic [2:0][scp_pkg::DivRemW-1:0]  rem_in;
        logic [2:0][scp_pkg::QuotW-1:0]    low_in;
        logic [2:0][scp_pkg::QuotW-1:0]    quot_in;
        scp_pkg::side_t                    side_in;
        logic [2:0][scp_pkg::DivRemW-1:0]  sh;
        logic [2:0]                        take;

        if (k == 0)
        begin : g_first
            assign vld_in  = init_valid_reg;
            assign len_in  = init_len_reg;
            assign rem_in  = init_rem_reg;
            assign low_in  = init_low_reg;
            assign quot_in = '0;
            assign side_in = init_side_reg;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign len_in  = len_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign low_in  = low_reg[k-1];
            assign quot_in = quot_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        for (genvar i = 0; i < 3; i++)
        begin : g_axis
            assign sh[i]   = {rem_in[i][scp_pkg::DivRemW-2:0], low_in[i][scp_pkg::QuotW-1]};
            assign take[i] = sh[i] >= scp_pkg::DivRemW'(len_in);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (advance)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                len_reg[k]  <= len_in;
                side_reg[k] <= side_in;
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[k][i]  <= take[i] ? sh[i] - scp_pkg::DivRemW'(len_in) : sh[i];
                    low_reg[k][i]  <= {low_in[i][scp_pkg::QuotW-2:0], 1'b0};
                    quot_reg[k][i] <= {quot_in[i][scp_pkg::QuotW-2:0], take[i]};
                end
            end
        end
    end

    assign out_valid = vld_reg[scp_pkg::DivSteps-1];
    assign out_quot  = quot_reg[scp_pkg::DivSteps-1];
    assign out_side  = side_reg[scp_pkg::DivSteps-1];

endmodule
`default_nettype wire

>>> rtl/sphere_collision_projection_top.sv
// Top level of the sphere collision projection block.
//
// Input channel in_valid/in_ready/in_data carries one particle position
// (three signed Q16.16 coordinates) per beat. Output channel
// out_valid/out_ready/out_data returns one beat per input: the position
// pushed out to the sphere surface (moved set) when it lies inside or on
// the sphere, otherwise the position unchanged; degenerate marks a
// particle exactly at the centre, left unchanged. Coordinates saturate to
// 32 bits. The user must write the sphere centre and radius through
// cfg_we/cfg_index/cfg_wdata only while the block is idle; the block does
// not enforce this. Other indexes are ignored. Three front stages, 32
// square-root stages and a rounding stage, a setup stage, 32 divider
// stages and the output register take one beat per cycle unless the
// receiver stalls. All stages advance together when the output register
// is empty or being taken; when the receiver stalls the whole pipeline
// holds, and in_ready drops in the same cycle. Reset clears every valid
// bit, sets the centre to zero and the radius to 1.0.
`default_nettype none
module sphere_collision_projection_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire scp_pkg::in_beat_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output scp_pkg::out_beat_t                  out_data,
    input  wire logic                           cfg_we,
    input  wire logic [scp_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [scp_pkg::CoordW-1:0]     cfg_wdata
);

    logic signed [scp_pkg::CoordW-1:0]   centre_x_reg;
    logic signed [scp_pkg::CoordW-1:0]   centre_y_reg;
    logic signed [scp_pkg::CoordW-1:0]   centre_z_reg;
    logic [scp_pkg::RadW-1:0]            radius_reg;

    logic                                advance;
    logic                                front_valid;
    logic [scp_pkg::SumW-1:0]            front_sum;
    scp_pkg::side_t                      front_side;
    logic                                sqrt_valid;
    logic [scp_pkg::RootW-1:0]           sqrt_len;
    scp_pkg::side_t                      sqrt_side;
    logic                                div_valid;
    logic [2:0][scp_pkg::QuotW-1:0]      div_quot;
    scp_pkg::side_t                      div_side;

    logic [2:0][scp_pkg::CoordW-1:0]     centre;
    logic [2:0][scp_pkg::CoordW-1:0]     pos;
    logic [2:0][scp_pkg::OffW-1:0]       off;
    logic [2:0][scp_pkg::OffW-1:0]       sum;
    logic [2:0][scp_pkg::CoordW-1:0]     res;

    logic                                out_valid_reg;
    scp_pkg::out_beat_t                  out_data_reg;
    scp_pkg::out_beat_t                  out_data_next;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            centre_z_reg <= '0;
            radius_reg   <= scp_pkg::RadiusReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                scp_pkg::CfgCentreX: centre_x_reg <= cfg_wdata;
                scp_pkg::CfgCentreY: centre_y_reg <= cfg_wdata;
                scp_pkg::CfgCentreZ: centre_z_reg <= cfg_wdata;
                scp_pkg::CfgRadius:  radius_reg   <= cfg_wdata[scp_pkg::RadW-1:0];
                default: ;
            endcase
        end
    end

    scp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (in_valid),
        .in_data  (in_data),
        .centre_x (centre_x_reg),
        .centre_y (centre_y_reg),
        .centre_z (centre_z_reg),
        .radius   (radius_reg),
        .out_valid(front_valid),
        .out_sum  (front_sum),
        .out_side (front_side)
    );

    scp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (front_valid),
        .in_sum   (front_sum),
        .in_side  (front_side),
        .out_valid(sqrt_valid),
        .out_len  (sqrt_len),
        .out_side (sqrt_side)
    );

    scp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (sqrt_valid),
        .in_len   (sqrt_len),
        .in_side  (sqrt_side),
        .out_valid(div_valid),
        .out_quot (div_quot),
        .out_side (div_side)
    );

    always_comb
    begin
        centre[0] = centre_x_reg;
        centre[1] = centre_y_reg;
        centre[2] = centre_z_reg;
        pos[0]    = div_side.pos.pos_x;
        pos[1]    = div_side.pos.pos_y;
        pos[2]    = div_side.pos.pos_z;
        for (int i = 0; i < 3; i++)
        begin
            off[i] = div_side.neg[i] ? scp_pkg::OffW'(-scp_pkg::OffW'(div_quot[i]))
                                     : scp_pkg::OffW'(div_quot[i]);
            sum[i] = {{2{centre[i][scp_pkg::CoordW-1]}}, centre[i]} + off[i];
            if (!sum[i][scp_pkg::OffW-1] && (sum[i][scp_pkg::OffW-2:scp_pkg::CoordW-1] != '0))
                res[i] = {1'b0, {(scp_pkg::CoordW-1){1'b1}}};
            else if (sum[i][scp_pkg::OffW-1] && (sum[i][scp_pkg::OffW-2:scp_pkg::CoordW-1] != '1))
                res[i] = {1'b1, {(scp_pkg::CoordW-1){1'b0}}};
            else
                res[i] = sum[i][scp_pkg::CoordW-1:0];
            if (!div_side.moved)
                res[i] = pos[i];
        end
        out_data_next.new_x      = res[0];
        out_data_next.new_y      = res[1];
        out_data_next.new_z      = res[2];
        out_data_next.moved      = div_side.moved;
        out_data_next.degenerate = div_side.degen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

>>> rtl/scp_checker.sv
// Port-level checks for the sphere collision projection block, bound to the top level.
`default_nettype none
module scp_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire scp_pkg::out_beat_t             out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output stall");

    a_moved_not_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.moved |-> !out_data.degenerate)
        else $error("beat flagged both moved and degenerate");

endmodule

bind sphere_collision_projection_top scp_checker u_scp_checker (.*);
`default_nettype wire
